### rtl/i2cws_pkg.sv
// Shared types and constants for the I2C write symbol sequencer.
package i2cws_pkg;

    // Bus symbol codes as they appear on the result channel.
    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT   = 2'd1,
        SYM_ACK   = 2'd2,
        SYM_STOP  = 2'd3
    } t_sym_code;

    // Configuration register indexes.
    localparam logic [1:0] REG_SLAVE_ADDR     = 2'd0;
    localparam logic [1:0] REG_COMMAND_PREFIX = 2'd1;
    localparam logic [1:0] REG_DATA_CTRL      = 2'd2;

    localparam logic [7:0] RST_SLAVE_ADDR     = 8'd120;
    localparam logic [7:0] RST_COMMAND_PREFIX = 8'd0;
    localparam logic [7:0] RST_DATA_CTRL      = 8'd64;

    // Item kind as carried in the cmd field.
    localparam logic KIND_COMMAND = 1'b0;

    // Slot positions in the longest frame: stop, start, three bytes of
    // eight bits and an ack each, stop. Every item covers a contiguous
    // range of these slots.
    localparam int SLOT_W = 5;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot SLOT_PRE_STOP  = 5'd0;
    localparam t_slot SLOT_START     = 5'd1;
    localparam t_slot SLOT_ADDR      = 5'd2;
    localparam t_slot SLOT_PREFIX    = 5'd11;
    localparam t_slot SLOT_DATA      = 5'd20;
    localparam t_slot SLOT_LAST_DATA = 5'd28;
    localparam t_slot SLOT_POST_STOP = 5'd29;

    // Bit offset within a byte at which the ack clock is sent.
    localparam logic [3:0] ACK_OFFSET = 4'd8;

    // One symbol as handed from the sequencer to the output register.
    typedef struct packed {
        t_sym_code symbol;
        logic      bit_level;
        logic      run_end;
    } t_sym_out;

endpackage

### rtl/i2cws_ifs.sv
// Channel interfaces: input items, result symbols and configuration writes.
interface i2cws_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output cmd, output byte_value, output last_byte,
                    input ready);
    modport sink   (input valid, input cmd, input byte_value, input last_byte,
                    output ready);
endinterface

interface i2cws_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       bit_level;
    logic       run_end;

    modport source (output valid, output symbol, output bit_level, output run_end,
                    input ready);
    modport sink   (input valid, input symbol, input bit_level, input run_end,
                    output ready);
endinterface

interface i2cws_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/i2cws_seq.sv
// Item buffer and slot sequencer that expands one byte item into bus symbols.
module i2cws_seq
    import i2cws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cws_in_if.sink   i_in,
    input  logic       i_advance,
    input  logic [7:0] i_slave_addr,
    input  logic [7:0] i_command_prefix,
    input  logic [7:0] i_data_ctrl,
    output logic       o_sym_valid,
    output t_sym_out   o_sym
);

    logic       r_pend_valid;
    logic       r_pend_data;
    logic [7:0] r_pend_byte;
    logic       r_pend_last;

    logic       r_act_valid;
    logic       r_act_data;
    logic [7:0] r_act_byte;
    t_slot      r_slot;
    t_slot      r_end;
    logic       r_open;

    logic       in_xfer;
    logic       act_done;
    logic       load;
    t_slot      n_slot;
    t_slot      n_end;
    logic       n_open;

    logic [7:0] cur_byte;
    logic [3:0] bit_off;

    assign i_in.ready = !r_pend_valid;
    assign in_xfer    = i_in.valid && !r_pend_valid;
    assign act_done   = r_act_valid && i_advance && (r_slot == r_end);
    assign load       = r_pend_valid && (!r_act_valid || act_done);

    // Slot range of the buffered item, from the transaction state it finds.
    always_comb begin
        if (r_pend_data == KIND_COMMAND) begin
            n_slot = r_open ? SLOT_PRE_STOP : SLOT_START;
            n_end  = SLOT_POST_STOP;
            n_open = 1'b0;
        end else begin
            n_slot = r_open ? SLOT_DATA : SLOT_START;
            n_end  = r_pend_last ? SLOT_POST_STOP : SLOT_LAST_DATA;
            n_open = !r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_act_valid  <= 1'b0;
            r_open       <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_pend_valid <= 1'b1;
            end else if (load) begin
                r_pend_valid <= 1'b0;
            end
            if (load) begin
                r_act_valid <= 1'b1;
                r_open      <= n_open;
            end else if (act_done) begin
                r_act_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pend_data <= i_in.cmd;
            r_pend_byte <= i_in.byte_value;
            r_pend_last <= i_in.last_byte;
        end
        if (load) begin
            r_act_data <= r_pend_data;
            r_act_byte <= r_pend_byte;
            r_slot     <= n_slot;
            r_end      <= n_end;
        end else if (r_act_valid && i_advance) begin
            r_slot <= r_slot + 5'd1;
        end
    end

    // Pick the byte that owns the current slot and the bit offset within it.
    always_comb begin
        if (r_slot < SLOT_PREFIX) begin
            cur_byte = i_slave_addr;
            bit_off  = 4'(r_slot - SLOT_ADDR);
        end else if (r_slot < SLOT_DATA) begin
            cur_byte = (r_act_data == KIND_COMMAND) ? i_command_prefix : i_data_ctrl;
            bit_off  = 4'(r_slot - SLOT_PREFIX);
        end else begin
            cur_byte = r_act_byte;
            bit_off  = 4'(r_slot - SLOT_DATA);
        end
    end

    always_comb begin
        o_sym.run_end   = (r_slot == r_end);
        o_sym.bit_level = 1'b0;
        if (r_slot == SLOT_PRE_STOP || r_slot == SLOT_POST_STOP) begin
            o_sym.symbol = SYM_STOP;
        end else if (r_slot == SLOT_START) begin
            o_sym.symbol = SYM_START;
        end else if (bit_off == ACK_OFFSET) begin
            o_sym.symbol = SYM_ACK;
        end else begin
            o_sym.symbol    = SYM_BIT;
            o_sym.bit_level = cur_byte[3'(3'd7 - bit_off[2:0])];
        end
    end

    assign o_sym_valid = r_act_valid;

endmodule

### rtl/i2c_write_symbol_sequencer_core.sv
// Top level of the write-only I2C symbol sequencer for a display controller.
// Each accepted item carries one byte, tagged as a command or as display data,
// and is expanded into bus symbols (start, data bit, ack clock, stop), one
// result transfer per symbol, each MSB-first byte being eight bit symbols and
// an ack clock. A command item is a complete transaction: start, device
// address, command prefix, the byte and stop; if a data transaction is still
// open, a stop closing it comes first, 30 symbols in all. Data items share one
// transaction: the first opens it with start, device address and data prefix,
// and an item with last_byte set closes it with stop. An item therefore
// expands into 9 to 30 symbols (29 for a lone command, 28 or
// 29 for the data byte that opens a transaction, 9 or 10 for a data byte
// inside an open transaction). The rate is set by the
// single symbol output register, which takes one symbol per cycle whenever it
// is empty or being drained; a one-item buffer ahead of the sequencer accepts
// the next item while the current one is still emitting, so back-to-back
// items produce an unbroken symbol stream. Configuration registers may be
// written at any time the block is idle; the configuration channel is always
// ready. There is no start-up sweep: the block is usable right after reset.
module i2c_write_symbol_sequencer_core
    import i2cws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cws_in_if.sink    i_in,
    i2cws_cfg_if.sink   i_cfg,
    i2cws_out_if.source o_out
);

    logic [7:0] r_slave_addr;
    logic [7:0] r_command_prefix;
    logic [7:0] r_data_ctrl;

    logic       r_out_valid;
    t_sym_out   r_out;

    logic       advance;
    logic       sym_valid;
    t_sym_out   sym;

    // Configuration writes are taken in any cycle; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr     <= RST_SLAVE_ADDR;
            r_command_prefix <= RST_COMMAND_PREFIX;
            r_data_ctrl      <= RST_DATA_CTRL;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SLAVE_ADDR:     r_slave_addr     <= i_cfg.data;
                REG_COMMAND_PREFIX: r_command_prefix <= i_cfg.data;
                REG_DATA_CTRL:      r_data_ctrl      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The sequencer moves one slot forward whenever the output register
    // can take a new symbol in this cycle.
    assign advance = !r_out_valid || o_out.ready;

    i2cws_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .i_advance        (advance),
        .i_slave_addr     (r_slave_addr),
        .i_command_prefix (r_command_prefix),
        .i_data_ctrl      (r_data_ctrl),
        .o_sym_valid      (sym_valid),
        .o_sym            (sym)
    );

    // Output register: holds a symbol until the sink takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= sym_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= sym;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.symbol    = r_out.symbol;
    assign o_out.bit_level = r_out.bit_level;
    assign o_out.run_end   = r_out.run_end;

endmodule

### rtl/i2cws_checker.sv
// Port-level checks on the symbol output of the sequencer, bound to the top level.
module i2cws_checker
    import i2cws_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_symbol,
    input logic       i_bit_level,
    input logic       i_run_end
);

    // A stalled result transfer keeps its valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result transfer keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_symbol) && $stable(i_bit_level) && $stable(i_run_end))
        else $error("output payload changed while stalled");

    // Only data bit symbols carry a nonzero SDA level.
    a_level_only_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_symbol != SYM_BIT |-> !i_bit_level)
        else $error("bit level set on a non-bit symbol");

    // An item's symbols end after an ack clock or a stop, never mid-byte.
    a_run_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_run_end |-> (i_symbol == SYM_ACK || i_symbol == SYM_STOP))
        else $error("item ended on a start or data bit symbol");

endmodule

bind i2c_write_symbol_sequencer_core i2cws_checker u_i2cws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_symbol    (o_out.symbol),
    .i_bit_level (o_out.bit_level),
    .i_run_end   (o_out.run_end)
);

### verif/i2c_write_symbol_sequencer_core_tb.sv
// Self-checking testbench for the I2C write symbol sequencer core.
module i2c_write_symbol_sequencer_core_tb
    import i2cws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        KIND_DATA      = ~KIND_COMMAND;
    localparam logic [1:0]  REG_NONE       = 2'd3;
    localparam int unsigned PHASE_ITEMS    = 85;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // Mirrors the framer: its own copy of the registers and of the open
    // transaction flag, and the symbols still owed on the output channel.
    class bus_symbol_scoreboard;
        logic [7:0]  slave_addr;
        logic [7:0]  command_prefix;
        logic [7:0]  data_ctrl;
        bit          transaction_open;
        t_sym_out    pending_symbols[$];
        int unsigned failures;

        function new();
            slave_addr       = RST_SLAVE_ADDR;
            command_prefix   = RST_COMMAND_PREFIX;
            data_ctrl        = RST_DATA_CTRL;
            transaction_open = 1'b0;
            failures         = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_SLAVE_ADDR:     slave_addr     = value;
                REG_COMMAND_PREFIX: command_prefix = value;
                REG_DATA_CTRL:      data_ctrl      = value;
                default: ;
            endcase
        endfunction

        function void push_symbol(t_sym_code code, logic level);
            t_sym_out entry;
            entry.symbol    = code;
            entry.bit_level = level;
            entry.run_end   = 1'b0;
            pending_symbols.push_back(entry);
        endfunction

        // A byte goes out MSB first, followed by one ack clock.
        function void push_byte(logic [7:0] value);
            for (int k = 7; k >= 0; k--) begin
                push_symbol(SYM_BIT, value[k]);
            end
            push_symbol(SYM_ACK, 1'b0);
        endfunction

        function void take_item(logic cmd, logic [7:0] value, logic last);
            t_sym_out tail;
            if (cmd == KIND_COMMAND) begin
                // A command first closes any open data transaction; its own
                // last flag has no effect.
                if (transaction_open) begin
                    push_symbol(SYM_STOP, 1'b0);
                    transaction_open = 1'b0;
                end
                push_symbol(SYM_START, 1'b0);
                push_byte(slave_addr);
                push_byte(command_prefix);
                push_byte(value);
                push_symbol(SYM_STOP, 1'b0);
            end else begin
                if (!transaction_open) begin
                    push_symbol(SYM_START, 1'b0);
                    push_byte(slave_addr);
                    push_byte(data_ctrl);
                    transaction_open = 1'b1;
                end
                push_byte(value);
                if (last) begin
                    push_symbol(SYM_STOP, 1'b0);
                    transaction_open = 1'b0;
                end
            end
            tail = pending_symbols.pop_back();
            tail.run_end = 1'b1;
            pending_symbols.push_back(tail);
        endfunction

        function void check_symbol(logic [1:0] symbol, logic level, logic run_end);
            t_sym_out owed;
            if (pending_symbols.size() == 0) begin
                failures++;
                $display("%0t: unexpected symbol: got symbol=%0d level=%0d end=%0d",
                         $time, symbol, level, run_end);
            end else begin
                owed = pending_symbols.pop_front();
                if (symbol !== owed.symbol || level !== owed.bit_level ||
                    run_end !== owed.run_end) begin
                    failures++;
                    $display("%0t: symbol/level/end expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, owed.symbol, owed.bit_level, owed.run_end,
                             symbol, level, run_end);
                end
            end
        endfunction

        function int unsigned owed_count();
            return pending_symbols.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    i2cws_in_if  in_ch();
    i2cws_out_if out_ch();
    i2cws_cfg_if cfg_ch();

    bus_symbol_scoreboard board;

    // Idling controls, changed by the stimulus between phases.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_request;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    i2c_write_symbol_sequencer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Result side: random stalls, plus one long hold-off on request so that
    // the block fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            out_ch.ready <= 1'b0;
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every transfer is seen here at the edge where it happens: register
    // writes and accepted items update the prediction, results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                board.write_register(cfg_ch.index, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                board.take_item(in_ch.cmd, in_ch.byte_value, in_ch.last_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                board.check_symbol(out_ch.symbol, out_ch.bit_level, out_ch.run_end);
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item after a random number of idle cycles and returns at the
    // edge where it is accepted; valid stays high for a following item.
    task automatic send_item(input logic cmd, input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.byte_value <= value;
        in_ch.last_byte  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stops offering and waits until every owed symbol has come out. The first
    // edge lets the monitor note an item accepted at the current edge.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.owed_count() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the three registers and then the unused index, whose write must
    // be ignored. Only called while the block is idle.
    task automatic program_registers(input logic [7:0] address, input logic [7:0] cmd_ctrl,
                                     input logic [7:0] dat_ctrl, input logic [7:0] junk);
        logic [1:0] indexes [4];
        logic [7:0] values [4];
        indexes = '{REG_SLAVE_ADDR, REG_COMMAND_PREFIX, REG_DATA_CTRL, REG_NONE};
        values  = '{address, cmd_ctrl, dat_ctrl, junk};
        for (int k = 0; k < 4; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= indexes[k];
            cfg_ch.data  <= values[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: lone commands and runs of data bytes closed
    // by a last byte. Some runs are left open so that the next command has to
    // close them, and a few data bytes carry last in mid-run.
    task automatic run_traffic(input int unsigned quota);
        int unsigned sent;
        int unsigned run_len;
        bit          leave_open;
        logic        last;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 40) begin
                send_item(KIND_COMMAND, 8'($urandom), 1'($urandom_range(1)));
                sent++;
            end else begin
                run_len    = $urandom_range(6, 1);
                leave_open = ($urandom_range(99) < 15);
                for (int k = 0; k < run_len; k++) begin
                    if (k == run_len - 1) begin
                        last = !leave_open;
                    end else begin
                        last = ($urandom_range(99) < 5);
                    end
                    send_item(KIND_DATA, 8'($urandom), last);
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int unsigned idle_plan  [4];
        int unsigned stall_plan [4];
        idle_plan  = '{0, 78, 0, 35};
        stall_plan = '{0, 0, 78, 35};

        board            = new();
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = KIND_COMMAND;
        in_ch.byte_value = 8'h00;
        in_ch.last_byte  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_SLAVE_ADDR;
        cfg_ch.data      = 8'h00;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_request     = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with the reset register values: byte extremes, a
        // command with last set, a data run, a data byte that opens and closes
        // its own transaction, and commands that arrive during open data.
        send_item(KIND_COMMAND, 8'h00, 1'b0);
        send_item(KIND_COMMAND, 8'hFF, 1'b1);
        send_item(KIND_DATA,    8'hA5, 1'b0);
        send_item(KIND_DATA,    8'h5A, 1'b0);
        send_item(KIND_DATA,    8'hFF, 1'b1);
        send_item(KIND_DATA,    8'h00, 1'b1);
        send_item(KIND_DATA,    8'h81, 1'b0);
        send_item(KIND_COMMAND, 8'h7E, 1'b0);
        send_item(KIND_DATA,    8'h01, 1'b0);
        send_item(KIND_DATA,    8'h80, 1'b0);
        send_item(KIND_COMMAND, 8'h80, 1'b1);
        send_item(KIND_COMMAND, 8'h55, 1'b0);
        send_item(KIND_DATA,    8'hAA, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0:       program_registers(8'h00, 8'hFF, 8'h00, 8'hFF);
                1:       program_registers(8'hFF, 8'h00, 8'hFF, 8'h00);
                default: program_registers(8'($urandom), 8'($urandom),
                                           8'($urandom), 8'($urandom));
            endcase
            send_idle_pct  = idle_plan[phase];
            recv_stall_pct = stall_plan[phase];

            if (phase == 0) begin
                // Long hold-off on the result side while items keep coming.
                hold_request = 1'b1;
                run_traffic(12);
            end
            if (phase == 3) begin
                // The sender stops mid-phase until the output has caught up.
                run_traffic(46);
                wait_drained();
            end
            run_traffic(PHASE_ITEMS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### i2c_write_symbol_sequencer_core.f
rtl/i2cws_pkg.sv
rtl/i2cws_ifs.sv
rtl/i2cws_seq.sv
rtl/i2c_write_symbol_sequencer_core.sv
rtl/i2cws_checker.sv
verif/i2c_write_symbol_sequencer_core_tb.sv
